// File: sv/msve_pkg.sv
// Shared types, constants and constant tables of the MIDI sine voice.
// Depends on nothing; every other file of the voice imports it.
`default_nettype none

package msve_pkg;

    // Sine table geometry and sample resolution.
    localparam int unsigned SINE_TABLE_DEPTH = 1024;
    localparam int unsigned SAMPLE_BITS      = 16;
    localparam int unsigned DEPTH_BITS       = $clog2(SINE_TABLE_DEPTH + 1) - 1;
    localparam int unsigned QTR_BITS         = DEPTH_BITS - 2;
    localparam int unsigned QTR_SIZE         = 1 << QTR_BITS;
    localparam int unsigned AMP_BITS         = SAMPLE_BITS - 1;
    localparam longint unsigned AMP_FULL     = (64'd1 << AMP_BITS) - 64'd1;
    localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;

    // Port field widths.
    localparam int unsigned OUT_BITS       = 16;
    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS  = 32;
    localparam int unsigned STEP_BITS      = 32;
    localparam int unsigned LEN_BITS       = 24;
    localparam int unsigned LEVEL_BITS     = 17;

    // The shared multiplier takes a 32-bit operand and a narrower one.
    localparam int unsigned MULB_BITS = (AMP_BITS > LEVEL_BITS) ? AMP_BITS : LEVEL_BITS;
    localparam int unsigned PROD_BITS = STEP_BITS + MULB_BITS;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_A4_PHASE_STEP  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ATTACK_LENGTH  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ATTACK_SLOPE   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE_SLOPE  = 3'd4;

    // Configuration reset values.
    localparam logic [STEP_BITS-1:0]  A4_STEP_RESET = 32'd39370534;
    localparam logic [LEN_BITS-1:0]   LENGTH_RESET  = 24'd4800;
    localparam logic [LEVEL_BITS-1:0] SLOPE_RESET   = 17'd14;

    // MIDI status nibbles.
    localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
    localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;

    // Note to octave and semitone: u = note + 3, u / 12 by reciprocal multiply.
    localparam logic [7:0] NOTE_OFFSET  = 8'd3;
    localparam int unsigned RECIP_12    = 171;
    localparam int unsigned RECIP_SHIFT = 11;
    localparam logic [3:0] SEMIS_PER_OCT = 4'd12;
    localparam logic [4:0] SHIFT_BASE   = 5'd22;

    typedef logic [LEVEL_BITS-1:0] t_level;
    typedef logic [AMP_BITS-1:0]   t_amp;
    typedef t_amp   t_qtr_tab  [QTR_SIZE];
    typedef t_level t_peak_tab [128];

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_NOTE_ON,
        CMD_NOTE_OFF
    } t_cmd_kind;

    // One classified item as it travels from the front end to the back end.
    typedef struct packed {
        t_cmd_kind   kind;
        logic [3:0]  semi;
        logic [4:0]  shift;
        t_level      peak;
    } t_cmd;

    localparam t_level SEMITONE_Q16 [12] = '{
        17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
        17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
    };

    localparam longint unsigned TAYLOR_DIV [7] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    // Restoring long division for the constant tables, evaluated at elaboration only.
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned quo;
        longint unsigned part;
        quo  = '0;
        part = '0;
        for (int b = 63; b >= 0; b--) begin
            part = {part[62:0], num[b]};
            if (part >= den) begin
                part   = part - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Q30 Taylor series of sin(x), evaluated at elaboration only.
    function automatic longint unsigned sin_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            term = udiv((term * x2) >> 30, TAYLOR_DIV[k-1]);
            if (k[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
        end
        return longint'(sum);
    endfunction

    function automatic t_amp sine_entry(input int unsigned i);
        longint unsigned ang;
        ang = (longint'(i) * HALF_PI_Q30 + longint'(QTR_SIZE / 2)) >> QTR_BITS;
        return AMP_BITS'((sin_q30(ang) * AMP_FULL + (64'd1 << 29)) >> 30);
    endfunction

    function automatic t_qtr_tab build_qtr_tab();
        t_qtr_tab tab;
        for (int unsigned i = 0; i < QTR_SIZE; i++) begin
            tab[i] = sine_entry(i);
        end
        return tab;
    endfunction

    function automatic t_peak_tab build_peak_tab();
        t_peak_tab tab;
        for (int unsigned v = 0; v < 128; v++) begin
            tab[v] = LEVEL_BITS'(udiv(longint'(v) * 64'd65536 + 64'd63, 64'd127));
        end
        return tab;
    endfunction

    // Quarter wave without its last point; the peak point is kept apart.
    localparam t_qtr_tab  SINE_QTR  = build_qtr_tab();
    localparam t_amp      SINE_PEAK = sine_entry(QTR_SIZE);
    localparam t_peak_tab PEAK_TAB  = build_peak_tab();

endpackage

`default_nettype wire

// File: sv/msve_ifs.sv
// Handshake channels of the MIDI sine voice: MIDI/tick input, sample output
// and configuration writes. Depends on msve_pkg.
`default_nettype none

interface msve_in_if;
    import msve_pkg::*;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] midi_status;
    logic [6:0] midi_note;
    logic [6:0] midi_velocity;
    modport source (output valid, operation, midi_status, midi_note, midi_velocity,
                    input ready);
    modport sink   (input valid, operation, midi_status, midi_note, midi_velocity,
                    output ready);
endinterface

interface msve_out_if;
    import msve_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] sample;
    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

interface msve_cfg_if;
    import msve_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/midi_sine_voice_envelope_core.sv
// Top level of one MIDI-driven sine voice with attack/release envelope.
// Depends on msve_pkg, the channel interfaces, msve_front, msve_queue, msve_back.
//
// Each input word is a MIDI event or a sample tick. Note-on (status 0x9n,
// velocity nonzero) sets pitch and peak level and starts the attack; note-off
// (0x8n, or 0x9n with velocity zero) starts the release; other status bytes
// are dropped. Every tick yields one signed 16-bit sample; MIDI events yield
// none. The front end classifies and registers a word and hands it through
// a four-word queue to the back end, which works on one command at a time
// with a single shared multiplier: a tick passes the fetch, envelope,
// multiply and emit states, a note-on fetch and note, a note-off fetch only.
// The input is taken while a finished sample still waits in the output
// register. Configuration is written with index 0 = A4 phase step, 1 = attack
// length, 2 = release length, 3 = attack slope, 4 = release slope; the user
// must write it only while the voice is idle, as the block does not enforce it.
`default_nettype none

module midi_sine_voice_envelope_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msve_in_if.sink    i_midi,
    msve_cfg_if.sink   i_cfg,
    msve_out_if.source o_smp
);
    import msve_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    msve_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_midi   (i_midi),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    msve_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (head_cmd),
        .o_empty (q_empty)
    );

    msve_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_smp     (o_smp),
        .i_q_empty (q_empty),
        .i_head    (head_cmd),
        .o_pop     (q_pop)
    );

endmodule

`default_nettype wire

// File: sv/msve_front.sv
// Front end: accepts input words, drops unknown MIDI status, and turns the
// rest into commands with octave shift, semitone and peak level precomputed.
// Depends on msve_pkg and msve_in_if.
`default_nettype none

module msve_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    msve_in_if.sink        i_midi,
    input  logic           i_q_full,
    output logic           o_push,
    output msve_pkg::t_cmd o_cmd
);
    import msve_pkg::*;

    logic        r_valid;
    t_cmd        r_cmd;
    t_cmd        cmd;
    logic        keep;
    logic        accept;
    logic [7:0]  u;
    logic [14:0] u_scaled;
    logic [3:0]  octave;
    logic [7:0]  rem;

    assign o_push       = r_valid && !i_q_full;
    assign o_cmd        = r_cmd;
    assign i_midi.ready = !r_valid || !i_q_full;
    assign accept       = i_midi.valid && i_midi.ready;

    always_comb begin
        u        = {1'b0, i_midi.midi_note} + NOTE_OFFSET;
        u_scaled = 15'(u * 15'(RECIP_12));
        octave   = 4'(u_scaled >> RECIP_SHIFT);
        rem      = u - 8'(octave * SEMIS_PER_OCT);

        cmd       = '0;
        cmd.semi  = rem[3:0];
        cmd.shift = SHIFT_BASE - {1'b0, octave};
        cmd.peak  = PEAK_TAB[i_midi.midi_velocity];
        keep      = 1'b1;
        if (i_midi.operation) begin
            cmd.kind = CMD_TICK;
        end else if (i_midi.midi_status[7:4] == MIDI_NOTE_ON && i_midi.midi_velocity != '0) begin
            cmd.kind = CMD_NOTE_ON;
        end else if (i_midi.midi_status[7:4] == MIDI_NOTE_ON ||
                     i_midi.midi_status[7:4] == MIDI_NOTE_OFF) begin
            cmd.kind = CMD_NOTE_OFF;
        end else begin
            cmd.kind = CMD_TICK;
            keep     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (accept && keep) begin
                r_valid <= 1'b1;
                r_cmd   <= cmd;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/msve_queue.sv
// Four-word command queue between the front end and the back end.
// Depends on msve_pkg.
`default_nettype none

module msve_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  msve_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output msve_pkg::t_cmd o_head,
    output logic           o_empty
);
    import msve_pkg::*;

    t_cmd       r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;

    assign o_full  = r_count == 3'd4;
    assign o_empty = r_count == 3'd0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 3'd1;
                2'b01:   r_count <= r_count - 3'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/msve_back.sv
// Back end: configuration registers, envelope, phase accumulator, sine
// lookup and the output sample register, around one shared multiplier.
// Depends on msve_pkg, msve_cfg_if and msve_out_if.
`default_nettype none

module msve_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    msve_cfg_if.sink       i_cfg,
    msve_out_if.source     o_smp,
    input  logic           i_q_empty,
    input  msve_pkg::t_cmd i_head,
    output logic           o_pop
);
    import msve_pkg::*;

    typedef enum logic [2:0] {
        ST_FETCH,
        ST_NOTE,
        ST_ENV,
        ST_MUL,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        ENV_IDLE,
        ENV_ATTACK,
        ENV_RELEASE
    } t_env_stage;

    // Configuration.
    logic [STEP_BITS-1:0] r_a4_step;
    logic [LEN_BITS-1:0]  r_att_len;
    logic [LEN_BITS-1:0]  r_rel_len;
    t_level               r_att_slope;
    t_level               r_rel_slope;

    // Voice state.
    t_state               r_state;
    t_env_stage           r_stage;
    logic [LEN_BITS-1:0]  r_pos;
    logic [STEP_BITS-1:0] r_phase;
    logic [STEP_BITS-1:0] r_step;
    t_level               r_level;
    t_level               r_peak;

    // Work registers.
    t_cmd                     r_cmd;
    logic [PROD_BITS-1:0]     r_prod;
    t_amp                     r_amp;
    logic                     r_neg;
    logic                     r_out_valid;
    logic [OUT_BITS-1:0]      r_out_sample;

    logic [STEP_BITS-1:0]     mul_a;
    logic [MULB_BITS-1:0]     mul_b;
    logic [PROD_BITS-1:0]     prod;
    logic [PROD_BITS-1:0]     rnd_sum;
    logic [STEP_BITS-1:0]     n_step;
    logic [PROD_BITS-1:0]     env_prod;
    logic [LEN_BITS-1:0]      n_pos;
    t_env_stage               n_stage;
    t_level                   n_level;
    logic [DEPTH_BITS-1:0]    tab_idx;
    logic [QTR_BITS-1:0]      off;
    logic [QTR_BITS-1:0]      off_mirror;
    t_amp                     n_amp;
    logic [PROD_BITS-1:0]     smp_rnd;
    logic [OUT_BITS-1:0]      mag16;
    logic [OUT_BITS-1:0]      n_sample;
    logic                     emit;

    assign i_cfg.ready  = 1'b1;
    assign o_smp.valid  = r_out_valid;
    assign o_smp.sample = r_out_sample;
    assign o_pop        = (r_state == ST_FETCH) && !i_q_empty;
    assign emit         = (r_state == ST_EMIT) && (!r_out_valid || o_smp.ready);

    // One multiplier serves the note pitch, the envelope ramp and the sample.
    always_comb begin
        if (r_state == ST_MUL) begin
            mul_a = STEP_BITS'(r_level);
            mul_b = MULB_BITS'(r_amp);
        end else if (i_head.kind == CMD_NOTE_ON) begin
            mul_a = r_a4_step;
            mul_b = MULB_BITS'(SEMITONE_Q16[i_head.semi]);
        end else begin
            mul_a = STEP_BITS'(r_pos);
            mul_b = (r_stage == ENV_RELEASE) ? MULB_BITS'(r_rel_slope)
                                             : MULB_BITS'(r_att_slope);
        end
        prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    end

    // Rounded right shift of the scaled A4 step by the octave.
    always_comb begin
        rnd_sum = r_prod + (PROD_BITS'(1) << (r_cmd.shift - 5'd1));
        n_step  = STEP_BITS'(rnd_sum >> r_cmd.shift);
    end

    // Envelope step for one tick.
    always_comb begin
        env_prod = r_prod;
        n_pos    = r_pos;
        n_stage  = r_stage;
        n_level  = r_level;
        case (r_stage)
            ENV_ATTACK: begin
                n_level = (env_prod < PROD_BITS'(r_peak)) ? LEVEL_BITS'(env_prod) : r_peak;
                n_pos   = r_pos + LEN_BITS'(1);
                if (n_pos >= r_att_len) begin
                    n_stage = ENV_IDLE;
                end
            end
            ENV_RELEASE: begin
                n_level = (env_prod < PROD_BITS'(r_peak))
                        ? r_peak - LEVEL_BITS'(env_prod) : '0;
                n_pos   = r_pos + LEN_BITS'(1);
                if (n_pos >= r_rel_len) begin
                    n_stage = ENV_IDLE;
                    n_level = '0;
                end
            end
            default: begin
                n_level = r_level;
            end
        endcase
    end

    // Quarter-wave lookup; odd quadrants run the table backwards.
    always_comb begin
        tab_idx    = r_phase[STEP_BITS-1 -: DEPTH_BITS];
        off        = tab_idx[QTR_BITS-1:0];
        off_mirror = -off;
        if (!tab_idx[DEPTH_BITS-2]) begin
            n_amp = SINE_QTR[off];
        end else if (off == '0) begin
            n_amp = SINE_PEAK;
        end else begin
            n_amp = SINE_QTR[off_mirror];
        end
    end

    always_comb begin
        smp_rnd  = r_prod + (PROD_BITS'(1) << 15);
        mag16    = smp_rnd[16 +: OUT_BITS];
        n_sample = r_neg ? -mag16 : mag16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a4_step   <= A4_STEP_RESET;
            r_att_len   <= LENGTH_RESET;
            r_rel_len   <= LENGTH_RESET;
            r_att_slope <= SLOPE_RESET;
            r_rel_slope <= SLOPE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_A4_PHASE_STEP:  r_a4_step   <= i_cfg.data;
                CFG_ATTACK_LENGTH:  r_att_len   <= i_cfg.data[LEN_BITS-1:0];
                CFG_RELEASE_LENGTH: r_rel_len   <= i_cfg.data[LEN_BITS-1:0];
                CFG_ATTACK_SLOPE:   r_att_slope <= i_cfg.data[LEVEL_BITS-1:0];
                CFG_RELEASE_SLOPE:  r_rel_slope <= i_cfg.data[LEVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FETCH;
            r_stage     <= ENV_IDLE;
            r_pos       <= '0;
            r_phase     <= '0;
            r_step      <= '0;
            r_level     <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_smp.valid && o_smp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_FETCH: begin
                    if (!i_q_empty) begin
                        r_cmd  <= i_head;
                        r_prod <= prod;
                        case (i_head.kind)
                            CMD_NOTE_ON: r_state <= ST_NOTE;
                            CMD_TICK:    r_state <= ST_ENV;
                            CMD_NOTE_OFF: begin
                                r_stage <= ENV_RELEASE;
                                r_pos   <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_NOTE: begin
                    r_step  <= n_step;
                    r_peak  <= r_cmd.peak;
                    r_stage <= ENV_ATTACK;
                    r_pos   <= '0;
                    r_state <= ST_FETCH;
                end
                ST_ENV: begin
                    r_level <= n_level;
                    r_pos   <= n_pos;
                    r_stage <= n_stage;
                    r_amp   <= n_amp;
                    r_neg   <= tab_idx[DEPTH_BITS-1];
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod  <= prod;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    // Wait for the output word to be taken before overwriting it.
                    if (emit) begin
                        r_out_sample <= n_sample;
                        r_phase      <= r_phase + r_step;
                        r_state      <= ST_FETCH;
                    end
                end
                default: r_state <= ST_FETCH;
            endcase
        end
    end

endmodule

`default_nettype wire
